>>> hdl/clat_pkg.sv
// Shared types and constants for the command line argument tokenizer.
// No dependencies; imported by command_line_arg_tokenizer.
`default_nettype none

package clat_pkg;

    // Character classes
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] TILDE_CHAR = 8'h7E;
    localparam logic [7:0] QUOTE_CHAR = 8'h22;

    // Register defaults and limits
    localparam logic [6:0] DEFAULT_MAX_LEN = 7'd51;
    localparam logic [6:0] COUNT_MAX       = 7'd127;

    // Register indexes (byte address bit 2)
    localparam logic REG_TARGET_INDEX = 1'b0;
    localparam logic REG_MAX_ARG_LEN  = 1'b1;

    // Result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One result request
    typedef struct packed {
        logic       item_kind;
        logic [7:0] arg_char;
        logic [6:0] arg_count;
        logic       arg_found;
        logic [6:0] arg_length;
        logic       last_result;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/command_line_arg_tokenizer.sv
// Command line argument tokenizer: per-character scanner with a small result queue.
// Depends on clat_pkg (types and constants).
//
//   channel   ports                              dir  payload
//   input     s_tvalid s_tready s_tdata s_tlast  in   char_in, end_of_line
//   result    m_tvalid m_tready m_tdata m_tuser  out  argument byte or line summary
//             m_tlast
//   config    psel penable pwrite paddr pwdata   in   target_index, max_arg_length
//             prdata pready
//
// One character is taken per cycle while s_tready is high; the scanner state
// updates at the accepting edge. Each character yields zero, one or two results
// into a four-entry result queue, which drains one per cycle while m_tready is
// high; input is taken while two queue entries are free.
// aresetn (synchronous) empties the queue and returns the scanner to between arguments.
`default_nettype none

module command_line_arg_tokenizer
    import clat_pkg::*;
#(
    parameter int MAX_LINE_LENGTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tlast,   // end_of_line
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] arg_char, [14:8] arg_count,
                                        // [15] arg_found, [22:16] arg_length, [23] zero
    output logic             m_tuser,   // [0] item_kind
    output logic             m_tlast,   // last_result
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LPW = $clog2(MAX_LINE_LENGTH + 1);

    typedef enum logic [1:0] {
        ST_GAP,
        ST_PLAIN,
        ST_QUOTED,
        ST_DISCARD
    } scan_t;

    // Configuration registers
    logic [5:0] target_index_reg;
    logic [6:0] max_arg_length_reg;

    // Line state
    scan_t          scan_reg,      scan_next;
    logic [6:0]     args_seen_reg, args_seen_next;
    logic [6:0]     emitted_reg,   emitted_next;
    logic           selected_reg,  selected_next;
    logic [LPW-1:0] line_pos_reg,  line_pos_next;

    // Result queue
    result_t    q_reg [4];
    logic [1:0] rd_ptr_reg, wr_ptr_reg;
    logic [2:0] count_reg;

    logic       s_accept, m_accept, cfg_write;
    logic       ws, data, emit_char, found;
    logic [6:0] args_step, emitted_step;
    result_t    char_res, sum_res;
    logic [1:0] push_n;

    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    // APB port
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_TARGET_INDEX: prdata = {26'd0, target_index_reg};
            REG_MAX_ARG_LEN:  prdata = {25'd0, max_arg_length_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_index_reg   <= '0;
            max_arg_length_reg <= DEFAULT_MAX_LEN;
        end else if (cfg_write) begin
            if (paddr[2] == REG_TARGET_INDEX) begin
                target_index_reg <= pwdata[5:0];
            end else begin
                max_arg_length_reg <= pwdata[6:0];
            end
        end
    end

    // Character scanner
    assign ws = (s_tdata <= SPACE_CHAR) || (s_tdata > TILDE_CHAR);

    always_comb begin
        scan_next      = scan_reg;
        args_seen_next = args_seen_reg;
        selected_next  = selected_reg;
        line_pos_next  = line_pos_reg;
        data           = 1'b0;
        if (line_pos_reg < LPW'(MAX_LINE_LENGTH)) begin
            line_pos_next = line_pos_reg + 1'b1;
            unique case (scan_reg)
                ST_GAP: begin
                    if (!ws) begin
                        selected_next = (args_seen_reg == {1'b0, target_index_reg});
                        if (args_seen_reg < COUNT_MAX) begin
                            args_seen_next = args_seen_reg + 7'd1;
                        end
                        if (s_tdata == QUOTE_CHAR) begin
                            scan_next = ST_QUOTED;
                        end else begin
                            scan_next = ST_PLAIN;
                            data      = 1'b1;
                        end
                    end
                end
                ST_PLAIN: begin
                    if (ws) scan_next = ST_GAP;
                    else    data = 1'b1;
                end
                ST_QUOTED: begin
                    if (s_tdata == QUOTE_CHAR) scan_next = ST_DISCARD;
                    else                       data = 1'b1;
                end
                ST_DISCARD: begin
                    if (ws) scan_next = ST_GAP;
                end
                default: scan_next = ST_GAP;
            endcase
        end
    end

    assign args_step    = args_seen_next;
    assign emit_char    = data && selected_next && (emitted_reg < max_arg_length_reg);
    assign emitted_step = emit_char ? emitted_reg + 7'd1 : emitted_reg;
    assign found        = (args_step > {1'b0, target_index_reg});

    // Results for this character
    always_comb begin
        char_res.item_kind   = KIND_CHAR;
        char_res.arg_char    = s_tdata;
        char_res.arg_count   = args_step;
        char_res.arg_found   = 1'b1;
        char_res.arg_length  = emitted_step;
        char_res.last_result = 1'b0;

        sum_res.item_kind    = KIND_SUMMARY;
        sum_res.arg_char     = 8'd0;
        sum_res.arg_count    = args_step;
        sum_res.arg_found    = found;
        sum_res.arg_length   = found ? emitted_step : 7'd0;
        sum_res.last_result  = 1'b1;

        push_n = {1'b0, emit_char} + {1'b0, s_tlast};
    end

    // End of line clears all line state
    assign emitted_next = s_tlast ? 7'd0 : emitted_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg      <= ST_GAP;
            args_seen_reg <= '0;
            emitted_reg   <= '0;
            selected_reg  <= 1'b0;
            line_pos_reg  <= '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                scan_reg      <= ST_GAP;
                args_seen_reg <= '0;
                selected_reg  <= 1'b0;
                line_pos_reg  <= '0;
            end else begin
                scan_reg      <= scan_next;
                args_seen_reg <= args_seen_next;
                selected_reg  <= selected_next;
                line_pos_reg  <= line_pos_next;
            end
            emitted_reg <= emitted_next;
        end
    end

    // Result queue: up to two pushes and one pop per cycle
    assign s_tready = (count_reg <= 3'd2);
    assign m_tvalid = (count_reg != 3'd0);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (emit_char) begin
                q_reg[wr_ptr_reg] <= char_res;
                if (s_tlast) q_reg[wr_ptr_reg + 2'd1] <= sum_res;
            end else if (s_tlast) begin
                q_reg[wr_ptr_reg] <= sum_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_accept) wr_ptr_reg <= wr_ptr_reg + push_n;
            if (m_accept) rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (s_accept ? {1'b0, push_n} : 3'd0)
                         - {2'd0, m_accept};
        end
    end

    // Output fields from the queue head
    always_comb begin
        m_tdata = {1'b0,
                   q_reg[rd_ptr_reg].arg_length,
                   q_reg[rd_ptr_reg].arg_found,
                   q_reg[rd_ptr_reg].arg_count,
                   q_reg[rd_ptr_reg].arg_char};
        m_tuser = q_reg[rd_ptr_reg].item_kind;
        m_tlast = q_reg[rd_ptr_reg].last_result;
    end

    // Checks
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overfilled");

    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> args_seen_reg == 7'd0 && line_pos_reg == '0
                                && emitted_reg == 7'd0)
        else $error("line state not cleared after end of line");

    a_char_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_CHAR) |-> m_tdata[15] && !m_tlast
                                              && (m_tdata[22:16] != 7'd0))
        else $error("argument byte without found flag or length");

    a_char_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_CHAR) |-> m_tdata[14:8] != 7'd0)
        else $error("argument byte with zero argument count");

endmodule

`default_nettype wire

>>> sim/tb_command_line_arg_tokenizer.sv
// Testbench for command_line_arg_tokenizer: drives command lines into the input stream,
// predicts every argument byte and line summary, and checks the result stream.
// Depends on clat_pkg and the command_line_arg_tokenizer top level.

module tb_command_line_arg_tokenizer
    import clat_pkg::*;
();

    localparam int LINE_MAX     = 128;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 180;

    typedef enum logic [1:0] {SCAN_GAP, SCAN_PLAIN, SCAN_QUOTED, SCAN_DISCARD} scan_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    command_line_arg_tokenizer #(.MAX_LINE_LENGTH(LINE_MAX)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Scanner copy: registers and line state
    logic [5:0] cfg_target;
    logic [6:0] cfg_maxlen;
    scan_t      scan_st;
    logic [6:0] arg_cnt;
    logic [6:0] emit_len;
    logic       sel_arg;
    int         line_pos;

    result_t    token_results[$];   // predicted argument bytes and summaries, oldest first
    logic [7:0] line_buf[$];        // line being sent
    int         mismatch_count = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b0;
    bit         hold_req = 1'b0;

    function automatic logic is_blank(input logic [7:0] c);
        return (c <= SPACE_CHAR) || (c > TILDE_CHAR);
    endfunction

    function automatic void clear_line();
        scan_st  = SCAN_GAP;
        arg_cnt  = '0;
        emit_len = '0;
        sel_arg  = 1'b0;
        line_pos = 0;
    endfunction

    // Predict the results of one accepted character
    function automatic void scan_char(input logic [7:0] c, input logic eol);
        logic    data;
        result_t r;
        data = 1'b0;
        if (line_pos < LINE_MAX) begin
            line_pos++;
            case (scan_st)
                SCAN_GAP: begin
                    if (!is_blank(c)) begin
                        sel_arg = (arg_cnt == {1'b0, cfg_target});
                        if (arg_cnt < COUNT_MAX)
                            arg_cnt++;
                        if (c == QUOTE_CHAR) begin
                            scan_st = SCAN_QUOTED;
                        end else begin
                            scan_st = SCAN_PLAIN;
                            data    = 1'b1;
                        end
                    end
                end
                SCAN_PLAIN: begin
                    if (is_blank(c))
                        scan_st = SCAN_GAP;
                    else
                        data = 1'b1;
                end
                SCAN_QUOTED: begin
                    if (c == QUOTE_CHAR)
                        scan_st = SCAN_DISCARD;
                    else
                        data = 1'b1;
                end
                default: begin
                    if (is_blank(c))
                        scan_st = SCAN_GAP;
                end
            endcase
            if (data && sel_arg && (emit_len < cfg_maxlen)) begin
                emit_len      = emit_len + 7'd1;
                r.item_kind   = KIND_CHAR;
                r.arg_char    = c;
                r.arg_count   = arg_cnt;
                r.arg_found   = 1'b1;
                r.arg_length  = emit_len;
                r.last_result = 1'b0;
                token_results.push_back(r);
            end
        end
        // line summary on the final character
        if (eol) begin
            r.item_kind   = KIND_SUMMARY;
            r.arg_char    = 8'h00;
            r.arg_count   = arg_cnt;
            r.arg_found   = (arg_cnt > {1'b0, cfg_target});
            r.arg_length  = r.arg_found ? emit_len : 7'd0;
            r.last_result = 1'b1;
            token_results.push_back(r);
            clear_line();
        end
    endfunction

    // Result checker
    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.item_kind   = m_tuser;
            got.arg_char    = m_tdata[7:0];
            got.arg_count   = m_tdata[14:8];
            got.arg_found   = m_tdata[15];
            got.arg_length  = m_tdata[22:16];
            got.last_result = m_tlast;
            if (token_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d char %h count %0d ",
                             got.item_kind, got.arg_char, got.arg_count,
                             "found %0d len %0d last %0d",
                             got.arg_found, got.arg_length, got.last_result);
            end else begin
                want = token_results.pop_front();
                if (got.item_kind !== want.item_kind || got.arg_char !== want.arg_char ||
                    got.arg_count !== want.arg_count || got.arg_found !== want.arg_found ||
                    got.arg_length !== want.arg_length || got.last_result !== want.last_result)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result: expected kind %0d char %h count %0d ",
                                 want.item_kind, want.arg_char, want.arg_count,
                                 "found %0d len %0d last %0d, ",
                                 want.arg_found, want.arg_length, want.last_result,
                                 "got kind %0d char %h count %0d ",
                                 got.item_kind, got.arg_char, got.arg_count,
                                 "found %0d len %0d last %0d",
                                 got.arg_found, got.arg_length, got.last_result);
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no request moving
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("command_line_arg_tokenizer: mismatch");
        $finish;
    end

    // Receiver: segments of varying readiness, plus a long hold on demand
    initial begin : receiver
        int seg_left;
        int ready_pct;
        seg_left  = 0;
        ready_pct = 100;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 50;
                    default: ready_pct = 20;
                endcase
            end
            seg_left--;
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Offer one character and wait for it to be taken; gaps between bursts if gaps_on
    task automatic send_char(input logic [7:0] c, input logic eol);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        scan_char(c, eol);
        @(negedge aclk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    // Stop offering and wait for every predicted result
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (token_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // APB write, then read back
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_TARGET_INDEX)
            cfg_target = value[5:0];
        else
            cfg_maxlen = value[6:0];
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        want = (idx == REG_TARGET_INDEX) ? {26'd0, cfg_target} : {25'd0, cfg_maxlen};
        if (prdata !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("register %0d read: expected %h, got %h", idx, want, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper bits are random so the field masking is exercised
    task automatic write_config(input logic [5:0] target, input logic [6:0] maxlen);
        wait_drain();
        write_reg(REG_TARGET_INDEX, ($urandom() & ~32'h3F) | {26'd0, target});
        write_reg(REG_MAX_ARG_LEN, ($urandom() & ~32'h7F) | {25'd0, maxlen});
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0, 1:    return SPACE_CHAR;
            2:       return 8'($urandom_range(1, 31));
            default: return 8'($urandom_range(127, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] pick_plain_start();
        logic [7:0] c;
        do c = pick_plain(); while (c == QUOTE_CHAR);
        return c;
    endfunction

    function automatic logic [7:0] pick_quoted();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == QUOTE_CHAR);
        return c;
    endfunction

    // Build one line: mostly well-formed argument lists, some noise and long lines
    task automatic make_line(input bit dense_bias);
        int kind;
        int nargs;
        int len;
        line_buf.delete();
        kind = $urandom_range(0, 19);
        if (dense_bias && kind < 10)
            kind = 2;
        if (kind < 2) begin
            // noise, quotes made common
            len = $urandom_range(1, 40);
            repeat (len)
                line_buf.push_back(($urandom_range(0, 7) == 0) ? QUOTE_CHAR
                                                              : 8'($urandom_range(1, 255)));
        end else if (kind == 2) begin
            // dense one-character arguments, up to 64 of them
            repeat ($urandom_range(55, 64)) begin
                line_buf.push_back(pick_plain_start());
                line_buf.push_back(pick_blank());
            end
        end else if (kind == 3) begin
            // one huge argument, which may run past the line limit
            repeat ($urandom_range(0, 2)) begin
                line_buf.push_back(pick_plain_start());
                line_buf.push_back(pick_blank());
            end
            len = $urandom_range(100, 160);
            if ($urandom_range(0, 1)) begin
                line_buf.push_back(QUOTE_CHAR);
                repeat (len) line_buf.push_back(pick_quoted());
            end else begin
                line_buf.push_back(pick_plain_start());
                repeat (len) line_buf.push_back(pick_plain());
            end
        end else begin
            nargs = $urandom_range(0, 8);
            repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
            for (int i = 0; i < nargs; i++) begin
                if (i > 0)
                    repeat ($urandom_range(1, 3)) line_buf.push_back(pick_blank());
                len = $urandom_range(0, 12);
                if ($urandom_range(0, 2) == 0) begin
                    // quoted; only the last one may stay open
                    line_buf.push_back(QUOTE_CHAR);
                    repeat (len) line_buf.push_back(pick_quoted());
                    if (i != nargs - 1 || $urandom_range(0, 3) != 0) begin
                        line_buf.push_back(QUOTE_CHAR);
                        repeat ($urandom_range(0, 3)) line_buf.push_back(pick_plain());
                    end
                end else begin
                    line_buf.push_back(pick_plain_start());
                    repeat (len) line_buf.push_back(pick_plain());
                end
            end
            repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
        end
        if (line_buf.size() == 0)
            line_buf.push_back(SPACE_CHAR);
    endtask

    // Short lines at reset settings: byte extremes, empty and open quotes, stray quotes
    task automatic test_directed();
        logic [8:0] seq[$];
        gaps_on = 1'b1;
        seq = '{
            {1'b1, 8'h61},
            {1'b1, SPACE_CHAR},
            {1'b0, QUOTE_CHAR}, {1'b1, QUOTE_CHAR},
            {1'b0, QUOTE_CHAR}, {1'b0, 8'hFF}, {1'b1, 8'h01},
            {1'b0, 8'h01}, {1'b0, 8'h61}, {1'b0, QUOTE_CHAR}, {1'b0, 8'h62}, {1'b1, 8'h7F},
            {1'b0, QUOTE_CHAR}, {1'b0, 8'h78}, {1'b0, QUOTE_CHAR}, {1'b0, 8'h79},
            {1'b0, SPACE_CHAR}, {1'b0, TILDE_CHAR}, {1'b1, 8'hFF},
            {1'b1, 8'h21}
        };
        foreach (seq[i])
            send_char(seq[i][7:0], seq[i][8]);
    endtask

    // Random lines under a sweep of register settings, extremes included
    task automatic test_random_phases();
        logic [5:0] targets[7];
        logic [6:0] lengths[7];
        int sent;
        targets = '{6'd0, 6'd63, 6'd2, 6'd1, 6'd5, 6'd0, 6'($urandom_range(0, 63))};
        lengths = '{7'd51, 7'd127, 7'd0, 7'd1, 7'd3, 7'd127, 7'($urandom_range(0, 127))};
        for (int p = 0; p < 7; p++) begin
            write_config(targets[p], lengths[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                make_line(targets[p] == 6'd63);
                gaps_on = ($urandom_range(0, 9) < 7);
                send_line();
                sent += line_buf.size();
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        int sent;
        write_config(6'd0, DEFAULT_MAX_LEN);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        sent = 0;
        while (sent < 60) begin
            make_line(1'b0);
            send_line();
            sent += line_buf.size();
        end
        wait_drain();
    endtask

    // Sender pauses until the result stream is empty, then resumes
    task automatic test_drain_pause();
        for (int k = 0; k < 4; k++) begin
            make_line(1'b0);
            gaps_on = 1'b1;
            send_line();
            wait_drain();
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        cfg_target = 6'd0;
        cfg_maxlen = DEFAULT_MAX_LEN;
        clear_line();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_phases();
        test_backpressure();
        test_drain_pause();

        wait_drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && token_results.size() == 0)
            $display("command_line_arg_tokenizer: match");
        else
            $display("command_line_arg_tokenizer: mismatch");
        $finish;
    end

endmodule
